// File: rtl/core/wrpf_pkg.sv
// ----------------------------------------------------------------------------
// wrpf_pkg
// Shared types, protocol constants and lookup functions for the window reply
// frame parser.
// ----------------------------------------------------------------------------
package wrpf_pkg;

  // Default frame store depth in bytes.
  localparam int MaxFrameDefault = 32;

  // Frame layout.
  localparam int MinLen       = 6;   // shortest frame that is checked at all
  localparam int HdrLen       = 6;   // STX, address, three window chars, command
  localparam int ReadOverhead = 9;   // header plus ETX-style tail on a read reply
  localparam int TailLen      = 3;   // bytes after the payload
  localparam int WinDigits    = 3;   // window number characters
  localparam int AlnumLen     = 10;  // field length of the alphanumeric type
  localparam int MaxPay       = 23;  // payload transactions per frame at most
  localparam int CntW         = 5;   // width of the payload counter

  // Protocol characters.
  localparam logic [7:0] CH_STX    = 8'h02;
  localparam logic [7:0] ADDR_LO   = 8'h80;
  localparam logic [7:0] ADDR_HI   = 8'h9F;
  localparam logic [7:0] ACK_0     = 8'h06;
  localparam logic [7:0] ACK_1     = 8'h03;
  localparam logic [7:0] ACK_2     = 8'h38;
  localparam logic [7:0] ACK_3     = 8'h35;
  localparam logic [7:0] CMD_READ  = 8'h30;
  localparam logic [7:0] PAD_NUM   = 8'h30;
  localparam logic [7:0] PAD_ALNUM = 8'h20;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  // Status codes reported on the first transaction of a frame.
  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_SHORT      = 4'd1,
    ST_STX        = 4'd2,
    ST_ADDR       = 4'd3,
    ST_ACK        = 4'd4,
    ST_INCOMPLETE = 4'd5,
    ST_NONDATA    = 4'd6,
    ST_CRC        = 4'd7,
    ST_OVERFLOW   = 4'd8
  } wrpf_status_t;

  // Window number decoder phase.
  typedef enum logic [1:0] {
    WM_BLANK,
    WM_DIGIT,
    WM_DONE
  } wrpf_wmode_t;

  // Running state of the window number decoder.
  typedef struct packed {
    wrpf_wmode_t mode;
    logic        neg;
    logic [9:0]  val;
  } wrpf_win_t;

  // Frame summary collected while bytes arrive.
  typedef struct packed {
    logic [5:0][7:0] hdr;
    logic [7:0]      tail1;      // last stored byte
    logic [7:0]      tail2;      // the byte before it
    logic [7:0]      xor_sum;    // XOR of all stored bytes but the first
    logic            overflowed;
  } wrpf_frame_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_RX,
    S_HDR,
    S_WIN,
    S_LEN,
    S_CHK,
    S_SCAN,
    S_SCANW,
    S_CNT,
    S_EMIT,
    S_PAYR,
    S_PAYO
  } wrpf_state_t;

  // Field length of a window number: 0 none, 1 logic, 6 numeric, 10 text.
  function automatic logic [3:0] wrpf_field_len(input logic [9:0] w);
    logic [3:0] len;
    case (w)
      10'd11, 10'd12, 10'd13, 10'd14, 10'd504: len = 4'd1;
      10'd108, 10'd205, 10'd206, 10'd503, 10'd505, 10'd600, 10'd610,
      10'd612, 10'd613, 10'd614, 10'd620, 10'd622, 10'd623, 10'd624,
      10'd630, 10'd632, 10'd633, 10'd634, 10'd640, 10'd642, 10'd643,
      10'd644, 10'd800, 10'd801, 10'd802, 10'd808, 10'd809, 10'd810,
      10'd812, 10'd820, 10'd822, 10'd830, 10'd832, 10'd840, 10'd842:
        len = 4'd6;
      10'd601, 10'd602, 10'd603, 10'd615, 10'd625, 10'd635, 10'd645,
      10'd803, 10'd804, 10'd811, 10'd821, 10'd831, 10'd841:
        len = 4'd10;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  // Uppercase ASCII hex character of a nibble.
  function automatic logic [7:0] wrpf_hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CH_ZERO + {4'd0, nib};
    end else begin
      c = CH_UPPER_A + {4'd0, nib} - 8'd10;
    end
    return c;
  endfunction

endpackage

// File: rtl/core/wrpf_mem.sv
// ----------------------------------------------------------------------------
// wrpf_mem
// Frame byte store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wrpf_mem #(
  parameter int Depth = 32,
  parameter int AW    = $clog2(Depth)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem_r [Depth];
  logic [7:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/wrpf_atoi.sv
// ----------------------------------------------------------------------------
// wrpf_atoi
// One step of the window number decoder: consumes one character and advances
// the blank, sign and digit scan.
// ----------------------------------------------------------------------------
module wrpf_atoi
  import wrpf_pkg::*;
(
  input  wrpf_win_t  cur,
  input  logic [7:0] ch,
  output wrpf_win_t  nxt
);

  logic is_blank;
  logic is_digit;
  logic is_sign;

  // Character classes.
  assign is_blank = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);

  // Scan step.
  always_comb begin
    nxt = cur;
    case (cur.mode)
      WM_BLANK: begin
        if (is_blank) begin
          nxt.mode = WM_BLANK;
        end else if (is_sign) begin
          nxt.mode = WM_DIGIT;
          nxt.neg  = (ch == CH_MINUS);
        end else if (is_digit) begin
          nxt.mode = WM_DIGIT;
          nxt.val  = {6'd0, ch[3:0]};
        end else begin
          nxt.mode = WM_DONE;
        end
      end
      WM_DIGIT: begin
        if (is_digit) begin
          nxt.val = cur.val * 10'd10 + {6'd0, ch[3:0]};
        end else begin
          nxt.mode = WM_DONE;
        end
      end
      default: nxt = cur;
    endcase
  end

endmodule

// File: rtl/core/wrpf_seq.sv
// ----------------------------------------------------------------------------
// wrpf_seq
// End-of-frame sequencer: runs the checks one step at a time, scans the pad
// bytes and the payload out of the frame store, and drives the result
// register.
// ----------------------------------------------------------------------------
module wrpf_seq
  import wrpf_pkg::*;
#(
  parameter int MAX_FRAME = MaxFrameDefault,
  parameter int AW        = $clog2(MAX_FRAME),
  parameter int CW        = $clog2(MAX_FRAME + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          frame_done,
  input  logic [CW-1:0] byte_count,
  input  wrpf_frame_t   frame,
  output logic          rx_busy,
  output logic          frame_clear,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [3:0]    out_status,
  output logic [9:0]    out_window_number,
  output logic [7:0]    out_command_byte,
  output logic [3:0]    out_field_length,
  output logic [7:0]    out_payload_byte,
  output logic          out_is_payload,
  output logic          out_last
);

  localparam int NW = CW + 1;

  wrpf_state_t  state_r, state_nxt;
  wrpf_status_t status_r, status_nxt;
  logic [9:0]   win_r, win_nxt;
  logic [7:0]   cmd_r, cmd_nxt;
  logic [3:0]   len_r, len_nxt;
  wrpf_win_t    wst_r, wst_nxt;
  logic [1:0]   wpos_r, wpos_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] start_r, start_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] k_r, k_nxt;
  logic [AW-1:0] pay_addr_r, pay_addr_nxt;

  logic         out_valid_r, out_valid_nxt;
  wrpf_status_t out_status_r, out_status_nxt;
  logic [9:0]   out_win_r, out_win_nxt;
  logic [7:0]   out_cmd_r, out_cmd_nxt;
  logic [3:0]   out_len_r, out_len_nxt;
  logic [7:0]   out_pay_r, out_pay_nxt;
  logic         out_isp_r, out_isp_nxt;
  logic         out_last_r, out_last_nxt;

  wrpf_win_t    wst_step;
  logic [7:0]   win_byte;
  logic         hdr_early;
  wrpf_status_t hdr_status;
  logic [7:0]   xor_x;
  logic         crc_ok;
  logic [NW-1:0] n_ext;
  logic         short_read;
  logic         scan_more;
  logic         pad_stop;
  logic [NW-1:0] tail_need;
  logic [NW-1:0] tail_diff;
  logic [CntW-1:0] cnt_calc;
  logic [9:0]   win_dec;
  logic         out_free;
  logic         pay_last;
  logic         load_status;
  logic         load_pay;

  // Window number decoder, stepped over the three window characters.
  assign win_byte = frame.hdr[3'(wpos_r) + 3'd2];

  wrpf_atoi u_atoi (
    .cur (wst_r),
    .ch  (win_byte),
    .nxt (wst_step)
  );

  assign win_dec = wst_r.neg ? 10'd0 : wst_r.val;

  // Early header checks, in priority order.
  always_comb begin
    hdr_early  = 1'b1;
    hdr_status = ST_OK;
    if (frame.overflowed) begin
      hdr_status = ST_OVERFLOW;
    end else if (byte_count < CW'(MinLen)) begin
      hdr_status = ST_SHORT;
    end else if (frame.hdr[0] != CH_STX) begin
      hdr_status = ST_STX;
    end else if ((frame.hdr[1] < ADDR_LO) || (frame.hdr[1] > ADDR_HI)) begin
      hdr_status = ST_ADDR;
    end else if ((byte_count == CW'(MinLen)) && (frame.hdr[2] == ACK_0) &&
                 (frame.hdr[3] == ACK_1) && (frame.hdr[4] == ACK_2) &&
                 (frame.hdr[5] == ACK_3)) begin
      hdr_status = ST_ACK;
    end else begin
      hdr_early = 1'b0;
    end
  end

  // Checksum and length checks.
  assign xor_x  = frame.xor_sum ^ frame.tail1 ^ frame.tail2;
  assign crc_ok = (frame.tail2 == wrpf_hex_char(xor_x[7:4])) &&
                  (frame.tail1 == wrpf_hex_char(xor_x[3:0]));
  assign n_ext  = {1'b0, byte_count};
  assign short_read = (cmd_r == CMD_READ) &&
                      (n_ext < NW'(ReadOverhead) + NW'(len_r));

  // Pad scan: bounded by the field length and by the frame end.
  assign scan_more = ({1'b0, idx_r} < NW'(HdrLen) + NW'(len_r)) &&
                     (idx_r < byte_count);
  assign pad_stop  = (len_r < 4'(AlnumLen)) ? (rd_data > PAD_NUM) :
                                               (rd_data > PAD_ALNUM);

  // Payload count: frame end minus the tail, capped.
  assign tail_need = {1'b0, start_r} + NW'(TailLen);
  assign tail_diff = n_ext - tail_need;
  always_comb begin
    if (n_ext < tail_need) begin
      cnt_calc = '0;
    end else if (tail_diff > NW'(MaxPay)) begin
      cnt_calc = CntW'(MaxPay);
    end else begin
      cnt_calc = tail_diff[CntW-1:0];
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign pay_last = ((k_r + CntW'(1)) == cnt_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_RX:    if (frame_done) state_nxt = S_HDR;
      S_HDR:   state_nxt = hdr_early ? S_EMIT : S_WIN;
      S_WIN:   if (wpos_r == 2'(WinDigits - 1)) state_nxt = S_LEN;
      S_LEN:   state_nxt = S_CHK;
      S_CHK: begin
        if (short_read || (len_r == 4'd0) || !crc_ok) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN:  state_nxt = scan_more ? S_SCANW : S_CNT;
      S_SCANW: state_nxt = pad_stop ? S_CNT : S_SCAN;
      S_CNT:   state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) state_nxt = (cnt_r == '0) ? S_RX : S_PAYR;
      end
      S_PAYR:  state_nxt = S_PAYO;
      S_PAYO: begin
        if (out_free) state_nxt = pay_last ? S_RX : S_PAYR;
      end
      default: state_nxt = S_RX;
    endcase
  end

  // State outputs.
  always_comb begin
    rx_busy     = (state_r != S_RX);
    rd_en       = 1'b0;
    rd_addr     = pay_addr_r;
    load_status = 1'b0;
    load_pay    = 1'b0;
    frame_clear = 1'b0;
    case (state_r)
      S_SCAN: begin
        rd_en   = scan_more;
        rd_addr = idx_r[AW-1:0];
      end
      S_PAYR: rd_en = 1'b1;
      S_EMIT: begin
        load_status = out_free;
        frame_clear = out_free && (cnt_r == '0);
      end
      S_PAYO: begin
        load_pay    = out_free;
        frame_clear = out_free && pay_last;
      end
      default: rd_en = 1'b0;
    endcase
  end

  // Working registers.
  always_comb begin
    status_nxt   = status_r;
    win_nxt      = win_r;
    cmd_nxt      = cmd_r;
    len_nxt      = len_r;
    wst_nxt      = wst_r;
    wpos_nxt     = wpos_r;
    idx_nxt      = idx_r;
    start_nxt    = start_r;
    cnt_nxt      = cnt_r;
    k_nxt        = k_r;
    pay_addr_nxt = pay_addr_r;
    case (state_r)
      S_HDR: begin
        cnt_nxt = '0;
        if (hdr_early) begin
          status_nxt = hdr_status;
          win_nxt    = '0;
          cmd_nxt    = '0;
          len_nxt    = '0;
        end else begin
          wst_nxt  = '{mode: WM_BLANK, neg: 1'b0, val: 10'd0};
          wpos_nxt = '0;
        end
      end
      S_WIN: begin
        wst_nxt  = wst_step;
        wpos_nxt = wpos_r + 2'd1;
      end
      S_LEN: begin
        win_nxt = win_dec;
        cmd_nxt = frame.hdr[5];
        len_nxt = wrpf_field_len(win_dec);
      end
      S_CHK: begin
        idx_nxt = CW'(HdrLen);
        if (short_read) begin
          status_nxt = ST_INCOMPLETE;
        end else if (len_r == 4'd0) begin
          status_nxt = ST_NONDATA;
        end else if (!crc_ok) begin
          status_nxt = ST_CRC;
        end else begin
          status_nxt = ST_OK;
        end
      end
      S_SCAN: begin
        if (!scan_more) start_nxt = idx_r;
      end
      S_SCANW: begin
        if (pad_stop) begin
          start_nxt = idx_r;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_CNT: begin
        cnt_nxt      = cnt_calc;
        k_nxt        = '0;
        pay_addr_nxt = start_r[AW-1:0];
      end
      S_PAYO: begin
        if (out_free) begin
          k_nxt        = k_r + CntW'(1);
          pay_addr_nxt = pay_addr_r + AW'(1);
        end
      end
      default: k_nxt = k_r;
    endcase
  end

  // Result register: loaded when empty or being taken.
  always_comb begin
    out_status_nxt = out_status_r;
    out_win_nxt    = out_win_r;
    out_cmd_nxt    = out_cmd_r;
    out_len_nxt    = out_len_r;
    out_pay_nxt    = out_pay_r;
    out_isp_nxt    = out_isp_r;
    out_last_nxt   = out_last_r;
    if (load_status || load_pay) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
    if (load_status) begin
      out_status_nxt = status_r;
      out_win_nxt    = win_r;
      out_cmd_nxt    = cmd_r;
      out_len_nxt    = len_r;
      out_pay_nxt    = 8'd0;
      out_isp_nxt    = 1'b0;
      out_last_nxt   = (cnt_r == '0);
    end else if (load_pay) begin
      out_status_nxt = ST_OK;
      out_win_nxt    = win_r;
      out_cmd_nxt    = cmd_r;
      out_len_nxt    = len_r;
      out_pay_nxt    = rd_data;
      out_isp_nxt    = 1'b1;
      out_last_nxt   = pay_last;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RX;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Data registers.
  always_ff @(posedge clk) begin
    status_r     <= status_nxt;
    win_r        <= win_nxt;
    cmd_r        <= cmd_nxt;
    len_r        <= len_nxt;
    wst_r        <= wst_nxt;
    wpos_r       <= wpos_nxt;
    idx_r        <= idx_nxt;
    start_r      <= start_nxt;
    cnt_r        <= cnt_nxt;
    k_r          <= k_nxt;
    pay_addr_r   <= pay_addr_nxt;
    out_status_r <= out_status_nxt;
    out_win_r    <= out_win_nxt;
    out_cmd_r    <= out_cmd_nxt;
    out_len_r    <= out_len_nxt;
    out_pay_r    <= out_pay_nxt;
    out_isp_r    <= out_isp_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_window_number = out_win_r;
  assign out_command_byte  = out_cmd_r;
  assign out_field_length  = out_len_r;
  assign out_payload_byte  = out_pay_r;
  assign out_is_payload    = out_isp_r;
  assign out_last          = out_last_r;

endmodule

// File: rtl/core/window_reply_frame_parser_top.sv
// ----------------------------------------------------------------------------
// window_reply_frame_parser_top
// Parses window protocol reply frames one byte at a time and reports a status
// transaction followed, on success, by the payload characters.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_rx_byte, in_frame_end) takes one
//   reply byte per transaction; in_frame_end marks the final byte. While bytes
//   arrive one transaction is taken every cycle. After the final byte the
//   block holds in_stall high while it checks the frame and emits results.
//   The result channel (out_valid, out_stall, out_*) gives one status
//   transaction per frame (out_is_payload low) and then up to 23 payload
//   transactions; out_last marks the final one of the frame.
//   After the final byte the header checks run first; on a failure the status is
//   emitted without the later checks. Else the window characters are decoded and
//   the length, type and checksum checked; on success the pad bytes are scanned
//   and the payload counted. Each payload byte is then read and loaded into the
//   result register once it is free. The sequencer reads the frame store one byte
//   per access through a registered port. A stalled receiver holds the result
//   register and the sequencer waits; the last result may sit in the register
//   while the next frame's bytes are already being taken.
//   Synchronous reset (rst_n low) empties the frame and the result register.
// ----------------------------------------------------------------------------
module window_reply_frame_parser_top
  import wrpf_pkg::*;
#(
  parameter int MAX_FRAME = MaxFrameDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_frame_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_status,
  output logic [9:0] out_window_number,
  output logic [7:0] out_command_byte,
  output logic [3:0] out_field_length,
  output logic [7:0] out_payload_byte,
  output logic       out_is_payload,
  output logic       out_last
);

  localparam int AW = $clog2(MAX_FRAME);
  localparam int CW = $clog2(MAX_FRAME + 1);

  logic [CW-1:0]   count_r, count_nxt;
  logic [7:0]      xor_r, xor_nxt;
  logic            ovf_r, ovf_nxt;
  logic [5:0][7:0] hdr_r, hdr_nxt;
  logic [7:0]      tail1_r, tail1_nxt;
  logic [7:0]      tail2_r, tail2_nxt;

  logic            rx_busy;
  logic            frame_clear;
  logic            accept;
  logic            store;
  logic            frame_done;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [7:0]      rd_data;
  wrpf_frame_t     frame;

  // Input transaction handling.
  assign in_stall   = rx_busy;
  assign accept     = in_valid && !rx_busy;
  assign store      = accept && (count_r < CW'(MAX_FRAME));
  assign frame_done = accept && in_frame_end;

  // Frame summary: count, running XOR, header bytes and the last two bytes.
  always_comb begin
    count_nxt = count_r;
    xor_nxt   = xor_r;
    ovf_nxt   = ovf_r;
    hdr_nxt   = hdr_r;
    tail1_nxt = tail1_r;
    tail2_nxt = tail2_r;
    if (frame_clear) begin
      count_nxt = '0;
      xor_nxt   = '0;
      ovf_nxt   = 1'b0;
    end else if (store) begin
      count_nxt = count_r + CW'(1);
      if (count_r != '0) xor_nxt = xor_r ^ in_rx_byte;
      for (int j = 0; j < HdrLen; j++) begin
        if (count_r == CW'(j)) hdr_nxt[j] = in_rx_byte;
      end
      tail1_nxt = in_rx_byte;
      tail2_nxt = tail1_r;
    end else if (accept) begin
      ovf_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      xor_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      xor_r   <= xor_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Captured bytes.
  always_ff @(posedge clk) begin
    hdr_r   <= hdr_nxt;
    tail1_r <= tail1_nxt;
    tail2_r <= tail2_nxt;
  end

  assign frame = '{hdr: hdr_r, tail1: tail1_r, tail2: tail2_r,
                   xor_sum: xor_r, overflowed: ovf_r};

  // Frame store.
  wrpf_mem #(
    .Depth (MAX_FRAME),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (store),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_rx_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Check and emit sequencer.
  wrpf_seq #(
    .MAX_FRAME (MAX_FRAME),
    .AW        (AW),
    .CW        (CW)
  ) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .frame_done        (frame_done),
    .byte_count        (count_r),
    .frame             (frame),
    .rx_busy           (rx_busy),
    .frame_clear       (frame_clear),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_window_number (out_window_number),
    .out_command_byte  (out_command_byte),
    .out_field_length  (out_field_length),
    .out_payload_byte  (out_payload_byte),
    .out_is_payload    (out_is_payload),
    .out_last          (out_last)
  );

endmodule
